### rtl/core/ugg_pkg.sv
// ----------------------------------------------------------------------------
// ugg_pkg
// Shared types and constants of the update gate governor: item layouts,
// opcodes, verdict codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package ugg_pkg;

  // Counter width of the step, accept and rollback counters
  localparam int unsigned CounterWidth = 32;

  // Opcodes
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_DECIDE  = 2'd1;
  localparam logic [1:0] OP_COMMIT  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Verdict codes
  localparam logic [2:0] VERDICT_ALLOW    = 3'd0;
  localparam logic [2:0] VERDICT_INVALID  = 3'd1;
  localparam logic [2:0] VERDICT_BUDGET   = 3'd2;
  localparam logic [2:0] VERDICT_COOLDOWN = 3'd3;
  localparam logic [2:0] VERDICT_NO_DRIFT = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_BASE_RATE       = 3'd0;
  localparam logic [2:0] REG_BYTE_BUDGET     = 3'd1;
  localparam logic [2:0] REG_COOLDOWN_STEPS  = 3'd2;
  localparam logic [2:0] REG_DRIFT_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_SHRINK_FACTOR   = 3'd4;

  // Configuration reset values
  localparam logic [23:0] BASE_RATE_RST       = 24'd167772;
  localparam logic [30:0] BYTE_BUDGET_RST     = 31'd1048576;
  localparam logic [15:0] COOLDOWN_STEPS_RST  = 16'd8;
  localparam logic [17:0] DRIFT_THRESHOLD_RST = 18'd3277;
  localparam logic [16:0] SHRINK_FACTOR_RST   = 17'd32768;

  // Fixed-point constants
  localparam logic [16:0] SIG_ONE    = 17'd65536;  // 1.0 in Q16
  localparam logic [17:0] SIG_TOL    = 18'd1311;   // 0.02 in Q16
  localparam logic [23:0] RATE_FLOOR = 24'd17;     // 1e-6 in Q0.24
  localparam logic [23:0] RATE_MAX   = 24'hFFFFFF;

  // Reciprocals for exact floor division: n/100 for n < 2^23, n/5 for n < 2^19
  localparam logic [23:0] DIV100_MUL   = 24'd10737419;
  localparam int unsigned DIV100_SHIFT = 30;
  localparam logic [18:0] DIV5_MUL     = 19'd419431;
  localparam int unsigned DIV5_SHIFT   = 21;

  // Input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [17:0] sigma_in;
    logic [31:0] byte_count;
  } ugg_in_t;

  // Result item
  typedef struct packed {
    logic                    allow;
    logic [2:0]              verdict;
    logic [23:0]             granted_rate;
    logic [30:0]             reserved_bytes;
    logic [17:0]             drift_out;
    logic [30:0]             used_bytes_out;
    logic [CounterWidth-1:0] applied_count;
    logic [CounterWidth-1:0] rollback_count;
  } ugg_out_t;

endpackage

### rtl/core/update_gate_governor.sv
// ----------------------------------------------------------------------------
// update_gate_governor
// Gate that tracks sigma in two moving-average bands and grants, commits or
// rolls back online model updates against a byte budget and a cooldown.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one opcode
//   item per transfer: observe, decide, commit or restart. Every item gives
//   exactly one result on the output channel (out_valid_o / out_stall_i /
//   out_data_o). An item sits in the input register, where the whole step is
//   computed against the governor state, and moves into the result register
//   once that register is free; out_valid_o then rises and holds until the
//   result transfer. Throughput is one item per cycle while the receiver
//   does not stall; the state update (band averages via reciprocal
//   multiplies, rate shrink multiply) is combinational and allows that rate.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_stall_o rises until the result is taken; nothing is lost.
//   Configuration writes (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i)
//   are always taken and should only be issued while the block is idle;
//   unknown indexes are ignored.
//   Reset clears both pipeline valid bits and all state, loads the register
//   reset values and sets the current rate to the base rate reset value.
// ----------------------------------------------------------------------------
module update_gate_governor
  import ugg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ugg_in_t     in_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ugg_out_t    out_data_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Configuration registers
  logic [23:0] base_rate_q;
  logic [30:0] byte_budget_q;
  logic [15:0] cooldown_q;
  logic [17:0] threshold_q;
  logic [16:0] shrink_q;

  // Governor state
  logic [16:0]             baseline_q, baseline_d;
  logic [16:0]             recent_q, recent_d;
  logic [CounterWidth-1:0] steps_q, steps_d;
  logic [30:0]             consumed_q, consumed_d;
  logic [23:0]             rate_q, rate_d;
  logic                    pending_q, pending_d;
  logic [CounterWidth-1:0] applied_q, applied_d;
  logic [CounterWidth-1:0] rollback_q, rollback_d;

  // Pipeline registers
  logic     in_valid_q;
  ugg_in_t  in_data_q;
  logic     out_valid_q;
  ugg_out_t out_data_q;
  ugg_out_t res_d;
  logic     adv;

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_rate_q   <= BASE_RATE_RST;
      byte_budget_q <= BYTE_BUDGET_RST;
      cooldown_q    <= COOLDOWN_STEPS_RST;
      threshold_q   <= DRIFT_THRESHOLD_RST;
      shrink_q      <= SHRINK_FACTOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BASE_RATE:       base_rate_q   <= cfg_data_i[23:0];
        REG_BYTE_BUDGET:     byte_budget_q <= cfg_data_i[30:0];
        REG_COOLDOWN_STEPS:  cooldown_q    <= cfg_data_i[15:0];
        REG_DRIFT_THRESHOLD: threshold_q   <= cfg_data_i[17:0];
        REG_SHRINK_FACTOR:   shrink_q      <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Handshake: the item in the input register moves on when the result slot frees
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---- Step datapath ----
  logic [16:0] sig_x;
  logic        bands_zero;
  logic [22:0] num_base;
  logic [46:0] prod_base;
  logic [18:0] num_recent;
  logic [37:0] prod_recent;
  logic [16:0] obs_baseline, obs_recent;
  logic [17:0] drift;
  logic        cnt_nonpos;
  logic [31:0] need_bytes;
  logic [32:0] commit_sum;
  logic [30:0] commit_bytes;
  logic [40:0] shrink_prod;
  logic [24:0] shrunk;
  logic [23:0] shrunk_sat;
  logic        regressed;
  logic [CounterWidth-1:0] steps_base;

  // Clamp sigma to 0..1.0
  always_comb begin
    if (in_data_q.sigma_in[17]) begin
      sig_x = '0;
    end else if (in_data_q.sigma_in[16:0] > SIG_ONE) begin
      sig_x = SIG_ONE;
    end else begin
      sig_x = in_data_q.sigma_in[16:0];
    end
  end

  // Band update: floor((99b + x)/100) and floor((4r + x)/5) by reciprocal multiply
  assign bands_zero  = (baseline_q == '0) && (recent_q == '0);
  assign num_base    = {baseline_q, 6'b0} + {1'b0, baseline_q, 5'b0}
                     + {4'b0, baseline_q, 2'b0} - {6'b0, baseline_q} + {6'b0, sig_x};
  assign prod_base   = num_base * DIV100_MUL;
  assign num_recent  = {recent_q, 2'b0} + {2'b0, sig_x};
  assign prod_recent = num_recent * DIV5_MUL;
  assign obs_baseline = bands_zero ? sig_x : prod_base[DIV100_SHIFT +: 17];
  assign obs_recent   = bands_zero ? sig_x : prod_recent[DIV5_SHIFT +: 17];

  // Decide checks
  assign drift      = {1'b0, recent_q} - {1'b0, baseline_q};
  assign cnt_nonpos = in_data_q.byte_count[31] || (in_data_q.byte_count == '0);
  assign need_bytes = {1'b0, in_data_q.byte_count[30:0]} + {1'b0, consumed_q};

  // Commit: byte total clamped to 0..budget
  assign commit_sum = {2'b0, consumed_q} + {in_data_q.byte_count[31], in_data_q.byte_count};
  always_comb begin
    if (commit_sum[32]) begin
      commit_bytes = '0;
    end else if (commit_sum[31:0] > {1'b0, byte_budget_q}) begin
      commit_bytes = byte_budget_q;
    end else begin
      commit_bytes = commit_sum[30:0];
    end
  end

  // Rollback: rate shrink with saturation and floor
  assign shrink_prod = rate_q * shrink_q;
  assign shrunk      = shrink_prod[40:16];
  always_comb begin
    shrunk_sat = shrunk[24] ? RATE_MAX : shrunk[23:0];
    if (shrunk_sat < RATE_FLOOR) begin
      shrunk_sat = RATE_FLOOR;
    end
  end

  assign regressed = {1'b0, sig_x} > ({1'b0, baseline_q} + SIG_TOL);

  // Next state and result
  always_comb begin
    baseline_d = baseline_q;
    recent_d   = recent_q;
    steps_d    = steps_q;
    consumed_d = consumed_q;
    rate_d     = rate_q;
    pending_d  = pending_q;
    applied_d  = applied_q;
    rollback_d = rollback_q;
    steps_base = steps_q;
    res_d      = '0;

    unique case (in_data_q.opcode)
      OP_OBSERVE: begin
        baseline_d = obs_baseline;
        recent_d   = obs_recent;
        steps_d    = (steps_q == '1) ? steps_q : steps_q + 1'b1;
      end
      OP_DECIDE: begin
        if (cnt_nonpos) begin
          res_d.verdict = VERDICT_INVALID;
        end else begin
          res_d.drift_out = drift;
          priority if (need_bytes > {1'b0, byte_budget_q}) begin
            res_d.verdict = VERDICT_BUDGET;
          end else if (steps_q < {{(CounterWidth-16){1'b0}}, cooldown_q}) begin
            res_d.verdict = VERDICT_COOLDOWN;
          end else if ($signed(drift) < $signed(threshold_q)) begin
            res_d.verdict = VERDICT_NO_DRIFT;
          end else begin
            res_d.verdict        = VERDICT_ALLOW;
            res_d.allow          = 1'b1;
            res_d.granted_rate   = rate_q;
            res_d.reserved_bytes = in_data_q.byte_count[30:0];
            pending_d            = 1'b1;
          end
        end
      end
      OP_COMMIT: begin
        if (pending_q && !regressed) begin
          consumed_d = commit_bytes;
          applied_d  = applied_q + 1'b1;
          steps_base = '0;
        end else if (pending_q) begin
          rate_d     = shrunk_sat;
          rollback_d = rollback_q + 1'b1;
          steps_base = '0;
        end
        pending_d  = 1'b0;
        baseline_d = obs_baseline;
        recent_d   = obs_recent;
        steps_d    = (steps_base == '1) ? steps_base : steps_base + 1'b1;
      end
      OP_RESTART: begin
        baseline_d = '0;
        recent_d   = '0;
        steps_d    = '0;
        consumed_d = '0;
        rate_d     = base_rate_q;
        pending_d  = 1'b0;
        applied_d  = '0;
        rollback_d = '0;
      end
      default: ;
    endcase

    res_d.used_bytes_out = consumed_d;
    res_d.applied_count  = applied_d;
    res_d.rollback_count = rollback_d;
  end

  // State registers, updated as the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      recent_q   <= '0;
      steps_q    <= '0;
      consumed_q <= '0;
      rate_q     <= BASE_RATE_RST;
      pending_q  <= 1'b0;
      applied_q  <= '0;
      rollback_q <= '0;
    end else if (adv) begin
      baseline_q <= baseline_d;
      recent_q   <= recent_d;
      steps_q    <= steps_d;
      consumed_q <= consumed_d;
      rate_q     <= rate_d;
      pending_q  <= pending_d;
      applied_q  <= applied_d;
      rollback_q <= rollback_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= res_d;
    end
  end

  // ---- Assertions ----
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result slot could take the item");

  a_bands_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (baseline_q <= SIG_ONE) && (recent_q <= SIG_ONE))
    else $error("sigma band left 0..1.0");

  a_pending_from_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> $past(adv && res_d.allow))
    else $error("pending grant set without an allowed decide");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_data_q.opcode == OP_RESTART)) |=>
      ((applied_q == '0) && (rollback_q == '0) && (consumed_q == '0) && !pending_q))
    else $error("restart left state behind");

endmodule

### tb/sv/ugg_gate_monitor.sv
// ----------------------------------------------------------------------------
// ugg_gate_monitor
// Watches the input, result and register channels of the update gate
// governor, tracks its own copy of the bands, counters and registers, and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ugg_gate_monitor
  import ugg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  ugg_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  ugg_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned outstanding_o,
  output int unsigned fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Register copy
  logic [23:0]        base_rate_q;
  logic [30:0]        byte_budget_q;
  logic [15:0]        cooldown_q;
  logic signed [17:0] drift_thr_q;
  logic [16:0]        shrink_q;

  // Governor state copy
  logic [16:0] slow_band;
  logic [16:0] fast_band;
  logic [31:0] steps_since;
  logic [30:0] used_bytes;
  logic [23:0] rate;
  logic        grant_open;
  logic [31:0] applied_total;
  logic [31:0] rolled_total;

  ugg_out_t    due_results[$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic restart_governor();
    slow_band     = '0;
    fast_band     = '0;
    steps_since   = '0;
    used_bytes    = '0;
    rate          = base_rate_q;
    grant_open    = 1'b0;
    applied_total = '0;
    rolled_total  = '0;
  endtask

  // One sigma observation: seed both bands from zero, else fold in
  task automatic fold_sigma(input longint x);
    longint s;
    longint f;
    s = slow_band;
    f = fast_band;
    if (s == 0 && f == 0) begin
      slow_band = 17'(x);
      fast_band = 17'(x);
    end else begin
      slow_band = 17'((99 * s + x) / 100);
      fast_band = 17'((4 * f + x) / 5);
    end
    if (steps_since != '1) steps_since = steps_since + 1;
  endtask

  task automatic predict_gate_step(input ugg_in_t item, output ugg_out_t res);
    longint x;
    longint cnt;
    longint s;
    longint f;
    longint drift;
    longint used;
    longint budget;
    longint thr;
    longint tol;
    longint sum;
    longint r;
    x      = $signed(item.sigma_in);
    cnt    = $signed(item.byte_count);
    s      = slow_band;
    f      = fast_band;
    used   = used_bytes;
    budget = byte_budget_q;
    thr    = drift_thr_q;
    tol    = SIG_TOL;
    if (x < 0) x = 0;
    if (x > longint'(SIG_ONE)) x = SIG_ONE;
    res = '0;
    case (item.opcode)
      OP_OBSERVE: begin
        fold_sigma(x);
      end
      OP_DECIDE: begin
        if (cnt <= 0) begin
          res.verdict = VERDICT_INVALID;
        end else begin
          drift = f - s;
          res.drift_out = 18'(drift);
          if (cnt + used > budget) begin
            res.verdict = VERDICT_BUDGET;
          end else if (steps_since < 32'(cooldown_q)) begin
            res.verdict = VERDICT_COOLDOWN;
          end else if (drift < thr) begin
            res.verdict = VERDICT_NO_DRIFT;
          end else begin
            res.verdict        = VERDICT_ALLOW;
            res.allow          = 1'b1;
            res.granted_rate   = rate;
            res.reserved_bytes = 31'(cnt);
            grant_open         = 1'b1;
          end
        end
      end
      OP_COMMIT: begin
        if (grant_open && !(x > s + tol)) begin
          // accept: byte total saturates to 0..budget
          sum = used + cnt;
          if (sum > budget) sum = budget;
          if (sum < 0) sum = 0;
          used_bytes    = 31'(sum);
          applied_total = applied_total + 1;
          steps_since   = '0;
        end else if (grant_open) begin
          // rollback: shrink the rate, keep it above the floor
          r = (longint'(rate) * longint'(shrink_q)) >>> 16;
          if (r > longint'(RATE_MAX)) r = RATE_MAX;
          if (r < longint'(RATE_FLOOR)) r = RATE_FLOOR;
          rate         = 24'(r);
          rolled_total = rolled_total + 1;
          steps_since  = '0;
        end
        grant_open = 1'b0;
        fold_sigma(x);
      end
      default: begin
        restart_governor();
      end
    endcase
    res.used_bytes_out = used_bytes;
    res.applied_count  = applied_total;
    res.rollback_count = rolled_total;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Register writes, predictions on input transfers, checks on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    ugg_out_t want;
    ugg_out_t got;
    if (!rst_ni) begin
      base_rate_q   = BASE_RATE_RST;
      byte_budget_q = BYTE_BUDGET_RST;
      cooldown_q    = COOLDOWN_STEPS_RST;
      drift_thr_q   = DRIFT_THRESHOLD_RST;
      shrink_q      = SHRINK_FACTOR_RST;
      restart_governor();
      due_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BASE_RATE:       base_rate_q   = cfg_data_i[23:0];
          REG_BYTE_BUDGET:     byte_budget_q = cfg_data_i[30:0];
          REG_COOLDOWN_STEPS:  cooldown_q    = cfg_data_i[15:0];
          REG_DRIFT_THRESHOLD: drift_thr_q   = cfg_data_i[17:0];
          REG_SHRINK_FACTOR:   shrink_q      = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_gate_step(in_data_i, want);
        due_results.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (due_results.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("allow", want.allow, got.allow);
          check_field("verdict", want.verdict, got.verdict);
          check_field("granted_rate", want.granted_rate, got.granted_rate);
          check_field("reserved_bytes", want.reserved_bytes, got.reserved_bytes);
          check_field("drift_out", $signed(want.drift_out), $signed(got.drift_out));
          check_field("used_bytes_out", want.used_bytes_out, got.used_bytes_out);
          check_field("applied_count", want.applied_count, got.applied_count);
          check_field("rollback_count", want.rollback_count, got.rollback_count);
        end
      end
      outstanding_o <= due_results.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the update gate governor with directed corner items and random
// observe/decide/commit rounds over several register settings, with bursty
// input and a patterned result stall; the gate monitor does the checking.
// ----------------------------------------------------------------------------
module tb_top
  import ugg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RoundsItems = 150;   // items per register setting
  localparam int unsigned NumSettings = 8;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  ugg_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ugg_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cur_budget  = BYTE_BUDGET_RST;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 0;
  int unsigned stall_tick = 0;

  always #5ns clk = ~clk;

  update_gate_governor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ugg_gate_monitor u_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result stall: switches to a randomly chosen pattern whenever its mode counter runs out
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(32, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_tick % 8) < 3);
    endcase
  end

  function automatic ugg_in_t make_item(input logic [1:0] op, input int sig, input int cnt);
    ugg_in_t it;
    it.opcode     = op;
    it.sigma_in   = sig[17:0];
    it.byte_count = cnt;
    return it;
  endfunction

  // One input transfer; gaps come between random-length bursts
  task automatic push_item(input ugg_in_t it);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and let every predicted result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes all five registers plus one write to an unused index
  task automatic program_regs(input logic [23:0] br, input logic [30:0] bb,
                              input logic [15:0] cd, input int dt,
                              input logic [16:0] sf);
    logic [2:0] unused_idx;
    unused_idx = 3'($urandom_range(5, 7));
    cfg_write(REG_BASE_RATE, 32'(br));
    cfg_write(REG_BYTE_BUDGET, 32'(bb));
    cfg_write(REG_COOLDOWN_STEPS, 32'(cd));
    cfg_write(REG_DRIFT_THRESHOLD, 32'(dt));
    cfg_write(REG_SHRINK_FACTOR, 32'(sf));
    cfg_write(unused_idx, $urandom);
    cfg_valid <= 1'b0;
    cur_budget = bb;
  endtask

  // Observation run that raises sigma, then a decide and usually a commit
  task automatic run_update_round();
    int unsigned lo;
    int unsigned hi;
    int unsigned n_obs;
    int unsigned cap;
    int          sig;
    int          bytes;
    if ($urandom_range(0, 5) == 0) push_item(make_item(OP_RESTART, $urandom, $urandom));
    lo    = $urandom_range(0, 30000);
    hi    = lo + $urandom_range(0, 40000);
    n_obs = $urandom_range(0, 14);
    for (int unsigned i = 0; i < n_obs; i++) begin
      sig = ((i < n_obs / 2) ? lo : hi) + int'($urandom_range(0, 1000)) - 500;
      if ($urandom_range(0, 7) == 0) sig = $urandom_range(0, 18'h3FFFF);
      push_item(make_item(OP_OBSERVE, sig, $urandom));
    end
    cap = (cur_budget / 32 > 1) ? cur_budget / 32 : 1;
    case ($urandom_range(0, 9))
      0:       bytes = -int'($urandom_range(0, 1000));
      1:       bytes = $urandom;
      default: bytes = $urandom_range(1, cap);
    endcase
    push_item(make_item(OP_DECIDE, $urandom_range(0, 18'h3FFFF), bytes));
    if ($urandom_range(0, 7) != 0) begin
      sig = $urandom_range(0, 1) ? int'($urandom_range(0, lo))
                                 : int'(hi + $urandom_range(2000, 60000));
      if ($urandom_range(0, 4) == 0) bytes = $urandom;
      push_item(make_item(OP_COMMIT, sig, bytes));
    end
  endtask

  initial begin
    int unsigned phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and every verdict under reset settings
    push_item(make_item(OP_OBSERVE, -131072, 0));
    push_item(make_item(OP_OBSERVE, 131071, -1));
    push_item(make_item(OP_DECIDE, 0, 0));
    push_item(make_item(OP_DECIDE, 0, 32'h8000_0000));
    push_item(make_item(OP_DECIDE, 0, 32'h7FFF_FFFF));
    push_item(make_item(OP_DECIDE, 0, 100));
    for (int i = 0; i < 6; i++) push_item(make_item(OP_OBSERVE, 65536, 0));
    push_item(make_item(OP_DECIDE, 0, 100));
    push_item(make_item(OP_COMMIT, 0, 5));       // no grant open
    push_item(make_item(OP_RESTART, 0, 0));
    push_item(make_item(OP_OBSERVE, 1, 0));
    for (int i = 0; i < 7; i++) push_item(make_item(OP_OBSERVE, 65536, 0));
    push_item(make_item(OP_DECIDE, 0, 1000));
    push_item(make_item(OP_COMMIT, 0, 1000));
    push_item(make_item(OP_DECIDE, 0, 1000));
    wait_idle();

    // Directed: rate floor, budget without overflow, byte total saturation
    program_regs(24'd17, 31'h7FFF_FFFF, 16'd0, -65536, 17'd0);
    push_item(make_item(OP_DECIDE, 0, 500));
    push_item(make_item(OP_COMMIT, 131071, 500));
    push_item(make_item(OP_DECIDE, 0, 32'h7FFF_FFFF));
    push_item(make_item(OP_DECIDE, 0, 700));
    push_item(make_item(OP_COMMIT, 0, 32'h8000_0000));
    push_item(make_item(OP_RESTART, 0, 0));
    push_item(make_item(OP_DECIDE, 0, 5));
    push_item(make_item(OP_COMMIT, 0, 32'h7FFF_FFFF));
    wait_idle();

    // Random rounds over several register settings
    for (int unsigned p = 0; p < NumSettings; p++) begin
      case (p)
        0: program_regs(BASE_RATE_RST, BYTE_BUDGET_RST, COOLDOWN_STEPS_RST,
                        int'($signed(DRIFT_THRESHOLD_RST)), SHRINK_FACTOR_RST);
        1: program_regs(24'd17, 31'd0, 16'd0, -65536, 17'd0);
        2: program_regs(24'hFFFFFF, 31'h7FFF_FFFF, 16'hFFFF, 65536, 17'd65536);
        default: program_regs(24'($urandom_range(17, 24'hFFFFFF)),
                              ($urandom_range(0, 3) == 0) ? 31'($urandom_range(0, 32'h7FFF_FFFF))
                                                          : 31'($urandom_range(1000, 2000000)),
                              16'($urandom_range(0, 12)),
                              int'($urandom_range(0, 11000)) - 3000,
                              17'($urandom_range(0, 65536)));
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + RoundsItems) begin
        if ($urandom_range(0, 6) == 0) begin
          push_item(make_item(2'($urandom_range(0, 3)), $urandom, $urandom));
        end else begin
          run_update_round();
        end
      end
      wait_idle();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
